>>> rtl/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the command line tokenizer
// Request structs, tokenizer state, character codes and a result builder.
// ----------------------------------------------------------------------------
package sct_pkg;

	// Sizing
	localparam int MAX_TOKEN_BYTES = 1024;
	localparam int LEN_W           = $clog2(MAX_TOKEN_BYTES);
	localparam int CFG_W           = 10;
	localparam int DEP_W           = 10;
	localparam int RES_N           = 3;
	localparam int CNT_W           = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 10'd1023;
	localparam logic [DEP_W-1:0] DEPTH_MAX = 10'd1023;

	// Character codes
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// Input request
	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_input;
	} in_req_t;

	// Output request
	typedef struct packed {
		logic [7:0] token_char;
		logic       char_valid;
		logic       token_end;
		logic       is_operator;
		logic       command_end;
		logic       overflow_error;
	} out_req_t;

	// Per-command tokenizer state
	typedef struct packed {
		logic [7:0]       held_char;
		logic             held_char_valid;
		logic [7:0]       held_operator;
		logic             held_operator_valid;
		logic [LEN_W-1:0] token_length;
		logic             in_single_quote;
		logic             in_double_quote;
		logic             escape_pending;
		logic [DEP_W-1:0] subshell_nesting;
		logic             dropping_after_error;
	} tok_state_t;

	// Load control from the step logic to the result buffer
	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] count;
	} obuf_ld_t;

	// Build a byte-carrying result
	function automatic out_req_t mk_res(input logic [7:0] ch, input logic tend,
			input logic op);
		out_req_t r;
		r = '0;
		r.token_char  = ch;
		r.char_valid  = 1'b1;
		r.token_end   = tend;
		r.is_operator = op;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/shell_command_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shell_command_tokenizer_top: shell-style command line tokenizer
// Takes one command byte per request and streams token bytes out with
// token, operator, command end and overflow marks.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+-------------
//  in      | in_valid, in_stall, in_data    | into      | in_req_t
//  out     | out_valid, out_stall, out_data | out of    | out_req_t
//  cfg     | cfg_we, cfg_wdata              | into      | max_token_chars
//
//  A request passes the input register, then one step of logic into the
//  result register, before its first result shows.
//  A byte is taken every cycle while each byte yields at most one result and
//  the output does not stall; a byte's results are handed out one by one.
//  Reset clears all tokenizer state and sets the limit to 1023.
//  An output stall backs up through the result register into in_stall.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire sct_pkg::in_req_t            in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output sct_pkg::out_req_t                out_data,
	input  wire logic                        cfg_we,
	input  wire logic [sct_pkg::CFG_W-1:0]   cfg_wdata
);
	import sct_pkg::*;

	in_req_t               in_s1;
	logic                  in_v_s1;
	tok_state_t            st_q;
	tok_state_t            nst;
	logic [CFG_W-1:0]      cfg_q;
	logic [LEN_W-1:0]      lim;
	out_req_t [RES_N-1:0]  res;
	logic [CNT_W-1:0]      cnt;
	logic                  free;
	logic                  move;
	logic                  in_take;
	obuf_ld_t              ld;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= CFG_RESET;
		else if (cfg_we)
			cfg_q <= cfg_wdata;
	end

	// Effective limit, clamped to 1 .. MAX_TOKEN_BYTES-1
	always_comb begin
		int lim_i;
		lim_i = int'(cfg_q);
		if (lim_i < 1)
			lim_i = 1;
		if (lim_i > MAX_TOKEN_BYTES - 1)
			lim_i = MAX_TOKEN_BYTES - 1;
		lim = LEN_W'(lim_i);
	end

	// Item leaves the input register when its results fit
	assign move     = in_v_s1 && ((cnt == '0) || free);
	assign in_stall = in_v_s1 && !move;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_v_s1 <= 1'b0;
		else if (in_take)
			in_v_s1 <= 1'b1;
		else if (move)
			in_v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take)
			in_s1 <= in_data;
	end

	// Tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (move)
			st_q <= nst;
	end

	sct_step u_step (
		.st  (st_q),
		.lim (lim),
		.din (in_s1),
		.nst (nst),
		.res (res),
		.cnt (cnt)
	);

	assign ld.load  = in_v_s1 && (cnt != '0);
	assign ld.count = cnt;

	sct_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

>>> rtl/sct_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_step: combinational tokenizer step
// Given the current state and one input byte, forms up to three results
// and the next state.
// ----------------------------------------------------------------------------
module sct_step (
	input  wire sct_pkg::tok_state_t                 st,
	input  wire logic [sct_pkg::LEN_W-1:0]           lim,
	input  wire sct_pkg::in_req_t                    din,
	output sct_pkg::tok_state_t                      nst,
	output sct_pkg::out_req_t [sct_pkg::RES_N-1:0]   res,
	output logic [sct_pkg::CNT_W-1:0]                cnt
);
	import sct_pkg::*;

	// Single pass over the byte: operator pairing, limit test, byte class, end
	always_comb begin
		tok_state_t                s;
		out_req_t [RES_N-1:0]      r;
		logic [CNT_W-1:0]          n;
		logic [7:0]                c;
		logic                      eoi;
		logic                      consumed;
		logic                      done;
		logic                      do_app;
		logic                      do_close;
		logic                      do_hold;
		logic                      do_opput;
		logic                      is_op;
		s        = st;
		r        = '0;
		n        = '0;
		c        = din.in_char;
		eoi      = din.end_of_input;
		consumed = 1'b0;
		done     = 1'b0;
		do_app   = 1'b0;
		do_close = 1'b0;
		do_hold  = 1'b0;
		do_opput = 1'b0;
		is_op    = (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) ||
			(c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_AMP);

		if (s.dropping_after_error) begin
			// discard bytes until the command ends
			if (eoi) begin
				r[0].command_end = 1'b1;
				n = CNT_W'(1);
				s = '0;
			end
		end else begin
			// resolve a held operator: pair or emit alone
			if (s.held_operator_valid) begin
				s.held_operator_valid = 1'b0;
				if (c == s.held_operator) begin
					r[n] = mk_res(s.held_operator, 1'b0, 1'b1);
					n = n + CNT_W'(1);
					r[n] = mk_res(c, 1'b1, 1'b1);
					n = n + CNT_W'(1);
					consumed = 1'b1;
				end else begin
					r[n] = mk_res(s.held_operator, 1'b1, 1'b1);
					n = n + CNT_W'(1);
				end
				s.held_operator = '0;
			end

			if (!consumed) begin
				if (s.token_length >= lim) begin
					// token too long: one error result
					r[n] = '0;
					r[n].overflow_error = 1'b1;
					r[n].command_end    = eoi;
					n = n + CNT_W'(1);
					s = '0;
					s.dropping_after_error = !eoi;
					done = 1'b1;
				end else begin
					// classify the byte
					if (s.escape_pending) begin
						do_app = 1'b1;
						s.escape_pending = 1'b0;
					end else if (!s.in_single_quote && !s.in_double_quote && is_op) begin
						if (c == CH_LPAREN && s.held_char_valid && s.held_char == CH_DOLLAR) begin
							if (s.subshell_nesting != DEPTH_MAX)
								s.subshell_nesting = s.subshell_nesting + DEP_W'(1);
							do_app = 1'b1;
						end else if (c == CH_RPAREN && s.subshell_nesting != '0) begin
							s.subshell_nesting = s.subshell_nesting - DEP_W'(1);
							do_app = 1'b1;
						end else if (s.subshell_nesting != '0) begin
							do_app = 1'b1;
						end else begin
							do_close = 1'b1;
							if (c == CH_AMP || c == CH_PIPE || c == CH_GT)
								do_hold = 1'b1;
							else
								do_opput = 1'b1;
						end
					end else if (c == CH_SPACE || c == CH_NL) begin
						if (s.in_single_quote || s.in_double_quote || s.subshell_nesting != '0)
							do_app = 1'b1;
						else
							do_close = 1'b1;
					end else if (c == CH_SQUOTE && !s.in_double_quote) begin
						s.in_single_quote = !s.in_single_quote;
					end else if (c == CH_DQUOTE && !s.in_single_quote) begin
						s.in_double_quote = !s.in_double_quote;
					end else if (c == CH_BSLASH && !s.in_double_quote && !s.in_single_quote) begin
						s.escape_pending = 1'b1;
					end else begin
						do_app = 1'b1;
					end

					// word end
					if (do_close) begin
						if (s.held_char_valid) begin
							r[n] = mk_res(s.held_char, 1'b1, 1'b0);
							n = n + CNT_W'(1);
						end
						s.held_char_valid = 1'b0;
						s.held_char       = '0;
						s.token_length    = '0;
					end
					// append: release the previously held byte
					if (do_app) begin
						if (s.held_char_valid) begin
							r[n] = mk_res(s.held_char, 1'b0, 1'b0);
							n = n + CNT_W'(1);
						end
						s.held_char       = c;
						s.held_char_valid = 1'b1;
						s.token_length    = s.token_length + LEN_W'(1);
					end
					if (do_hold) begin
						s.held_operator       = c;
						s.held_operator_valid = 1'b1;
					end
					if (do_opput) begin
						r[n] = mk_res(c, 1'b1, 1'b1);
						n = n + CNT_W'(1);
					end
				end
			end

			// command end: flush held bytes, mark the last result
			if (eoi && !done) begin
				if (s.held_operator_valid) begin
					r[n] = mk_res(s.held_operator, 1'b1, 1'b1);
					n = n + CNT_W'(1);
				end
				if (s.held_char_valid) begin
					r[n] = mk_res(s.held_char, 1'b1, 1'b0);
					n = n + CNT_W'(1);
				end
				if (n != '0) begin
					r[n - CNT_W'(1)].command_end = 1'b1;
				end else begin
					r[0].command_end = 1'b1;
					n = CNT_W'(1);
				end
				s = '0;
			end
		end

		nst = s;
		res = r;
		cnt = n;
	end

endmodule
`default_nettype wire

>>> rtl/sct_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_obuf: result register
// Holds the up to three results of one step and hands them out one per
// request, in order.
// ----------------------------------------------------------------------------
module sct_obuf (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sct_pkg::obuf_ld_t                   ld,
	input  wire sct_pkg::out_req_t [sct_pkg::RES_N-1:0] res,
	output logic                                     free,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output sct_pkg::out_req_t                        out_data
);
	import sct_pkg::*;

	out_req_t [RES_N-1:0] slot_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     rd_q;
	logic                 take;

	assign out_valid = (rem_q != '0);
	assign out_data  = slot_q[rd_q];
	assign take      = out_valid && !out_stall;
	// empty now, or the last result leaves this cycle
	assign free      = (rem_q == '0) || (rem_q == CNT_W'(1) && take);

	// Result slots
	always_ff @(posedge clk) begin
		if (ld.load && free)
			slot_q <= res;
	end

	// Read pointer and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (ld.load && free) begin
			rem_q <= ld.count;
			rd_q  <= '0;
		end else if (take) begin
			rem_q <= rem_q - CNT_W'(1);
			rd_q  <= rd_q + CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/tb_shell_command_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_command_tokenizer_top: self-checking bench for the command tokenizer
// A queue of command bytes and limit writes feeds a clocked driver. A clocked
// monitor predicts the token stream of every taken byte and compares each
// result, field by field, in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_shell_command_tokenizer_top;
	import sct_pkg::*;

	localparam int SETTLE       = 8;       // idle cycles before a limit write
	localparam int LONG_HOLD    = 120;     // long output back-pressure stretch
	localparam int TAIL_STEPS   = 40;      // final stretch without idling
	localparam int DRAIN_CYCLES = 20;
	localparam int TIMEOUT_NS   = 5_000_000;

	typedef enum logic [1:0] {ST_BYTE, ST_LIMIT, ST_DRAIN, ST_HOLD} step_kind_e;

	typedef struct packed {
		step_kind_e       kind;
		in_req_t          rq;
		logic [CFG_W-1:0] lim;
	} tb_step_t;

	// DUT signals
	logic             clk;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_req_t          in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_req_t         out_data;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = CFG_RESET;

	// Stimulus and scoreboard
	tb_step_t pending_steps[$];
	out_req_t expected_tokens[$];
	out_req_t step_results[$];
	int       queued_bytes   = 0;
	int       sent_count     = 0;
	int       got_count      = 0;
	int       mismatch_count = 0;
	int       quiet_cycles   = 0;
	int       gap_left       = 0;
	int       hold_left      = 0;
	int       stall_left     = 0;
	logic     fill_done      = 1'b0;
	logic     tail_phase     = 1'b0;
	logic     hold_go        = 1'b0;

	// Predictor copy of the limit register and of the tokenizer state
	logic [CFG_W-1:0] tok_limit   = CFG_RESET;
	logic [7:0]       tk_held     = '0;
	logic             tk_held_ok  = 1'b0;
	logic [7:0]       tk_op       = '0;
	logic             tk_op_ok    = 1'b0;
	int               tk_len      = 0;
	logic             tk_squote   = 1'b0;
	logic             tk_dquote   = 1'b0;
	logic             tk_escape   = 1'b0;
	int               tk_depth    = 0;
	logic             tk_dropping = 1'b0;

	shell_command_tokenizer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Token predictor
	// ------------------------------------------------------------------
	function automatic void add_result(input logic [7:0] ch, input logic cv,
			input logic te, input logic op, input logic ce, input logic er);
		out_req_t r;
		r = '0;
		r.token_char     = cv ? ch : 8'h00;
		r.char_valid     = cv;
		r.token_end      = te;
		r.is_operator    = op;
		r.command_end    = ce;
		r.overflow_error = er;
		step_results.push_back(r);
	endfunction

	// previous held byte goes out, new byte becomes the held one
	function automatic void grow_word(input logic [7:0] c);
		if (tk_held_ok)
			add_result(tk_held, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		tk_held    = c;
		tk_held_ok = 1'b1;
		tk_len++;
	endfunction

	function automatic void end_word();
		if (tk_held_ok)
			add_result(tk_held, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		tk_held_ok = 1'b0;
		tk_held    = '0;
		tk_len     = 0;
	endfunction

	function automatic void clear_command();
		tk_held     = '0;
		tk_held_ok  = 1'b0;
		tk_op       = '0;
		tk_op_ok    = 1'b0;
		tk_len      = 0;
		tk_squote   = 1'b0;
		tk_dquote   = 1'b0;
		tk_escape   = 1'b0;
		tk_depth    = 0;
		tk_dropping = 1'b0;
	endfunction

	function automatic void predict_tokens(input in_req_t rq);
		logic [7:0] c;
		logic       eoi;
		logic       paired;
		int         lim;
		c      = rq.in_char;
		eoi    = rq.end_of_input;
		paired = 1'b0;
		lim    = (tok_limit == 0) ? 1 : int'(tok_limit);
		step_results.delete();
		if (tk_dropping) begin
			// after an overflow only the command end matters
			if (eoi) begin
				add_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
				clear_command();
			end
		end else begin
			// resolve a waiting operator: pair it or emit it alone
			if (tk_op_ok) begin
				tk_op_ok = 1'b0;
				if (c == tk_op) begin
					add_result(tk_op, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
					add_result(c, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
					paired = 1'b1;
				end else begin
					add_result(tk_op, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
				end
				tk_op = '0;
			end
			if (!paired && tk_len >= lim) begin
				add_result(8'h00, 1'b0, 1'b0, 1'b0, eoi, 1'b1);
				clear_command();
				if (!eoi)
					tk_dropping = 1'b1;
			end else begin
				if (!paired) begin
					if (tk_escape) begin
						grow_word(c);
						tk_escape = 1'b0;
					end else if (!tk_squote && !tk_dquote && (c == CH_PIPE || c == CH_LT ||
							c == CH_GT || c == CH_LPAREN || c == CH_RPAREN || c == CH_AMP)) begin
						// operator bytes, unless inside a subshell
						if (c == CH_LPAREN && tk_held_ok && tk_held == CH_DOLLAR) begin
							if (tk_depth < int'(DEPTH_MAX))
								tk_depth++;
							grow_word(c);
						end else if (c == CH_RPAREN && tk_depth > 0) begin
							tk_depth--;
							grow_word(c);
						end else if (tk_depth > 0) begin
							grow_word(c);
						end else begin
							end_word();
							if (c == CH_AMP || c == CH_PIPE || c == CH_GT) begin
								tk_op    = c;
								tk_op_ok = 1'b1;
							end else begin
								add_result(c, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
							end
						end
					end else if (c == CH_SPACE || c == CH_NL) begin
						if (tk_squote || tk_dquote || tk_depth > 0)
							grow_word(c);
						else
							end_word();
					end else if (c == CH_SQUOTE && !tk_dquote) begin
						tk_squote = !tk_squote;
					end else if (c == CH_DQUOTE && !tk_squote) begin
						tk_dquote = !tk_dquote;
					end else if (c == CH_BSLASH && !tk_dquote && !tk_squote) begin
						tk_escape = 1'b1;
					end else begin
						grow_word(c);
					end
				end
				// command end flushes whatever is held
				if (eoi) begin
					if (tk_op_ok)
						add_result(tk_op, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
					end_word();
					if (step_results.size() > 0)
						step_results[step_results.size() - 1].command_end = 1'b1;
					else
						add_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
					clear_command();
				end
			end
		end
		foreach (step_results[i])
			expected_tokens.push_back(step_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] ch, input logic last);
		tb_step_t s;
		s                 = '0;
		s.kind            = ST_BYTE;
		s.rq.in_char      = ch;
		s.rq.end_of_input = last;
		pending_steps.push_back(s);
		queued_bytes++;
	endtask

	task automatic queue_mark(input step_kind_e kind, input logic [CFG_W-1:0] lim);
		tb_step_t s;
		s      = '0;
		s.kind = kind;
		s.lim  = lim;
		pending_steps.push_back(s);
	endtask

	// one command: mostly word bytes with shell syntax mixed in, sometimes raw noise
	task automatic queue_random_command(input int max_len);
		int         n;
		logic [7:0] c;
		logic [7:0] prev;
		logic       noise;
		n     = $urandom_range(1, max_len);
		noise = ($urandom_range(0, 7) == 0);
		prev  = 8'h61;
		for (int k = 0; k < n; k++) begin
			if (noise) begin
				c = 8'($urandom_range(0, 255));
			end else begin
				case ($urandom_range(0, 15))
					0: c = CH_SPACE;
					1: c = CH_NL;
					2: begin
						case ($urandom_range(0, 5))
							0: c = CH_PIPE;
							1: c = CH_LT;
							2: c = CH_GT;
							3: c = CH_LPAREN;
							4: c = CH_RPAREN;
							default: c = CH_AMP;
						endcase
					end
					3: c = prev;
					4: c = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
					5: c = CH_BSLASH;
					6: begin
						queue_byte(CH_DOLLAR, 1'b0);
						c = CH_LPAREN;
					end
					7: c = CH_RPAREN;
					8: c = 8'($urandom_range(0, 255));
					default: c = 8'(8'h61 + $urandom_range(0, 25));
				endcase
			end
			queue_byte(c, k == n - 1);
			prev = c;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: requests from the pending queue, limit writes when idle
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_blk
		tb_step_t nxt;
		logic     nv;
		in_req_t  nd;
		logic     nwe;
		logic     nhold;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			in_data      <= '0;
			cfg_we       <= 1'b0;
			cfg_wdata    <= CFG_RESET;
			hold_go      <= 1'b0;
			gap_left     <= 0;
			quiet_cycles <= 0;
			tok_limit    <= CFG_RESET;
			tail_phase   <= 1'b0;
		end else begin
			nv    = in_valid;
			nd    = in_data;
			nwe   = 1'b0;
			nhold = 1'b0;
			if (in_valid || out_valid || expected_tokens.size() != 0)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			// a stalled request holds; otherwise pick the next step
			if (!(in_valid && in_stall)) begin
				nv = 1'b0;
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_steps.size() != 0) begin
					nxt = pending_steps[0];
					case (nxt.kind)
						ST_BYTE: begin
							nv  = 1'b1;
							nd  = nxt.rq;
							nxt = pending_steps.pop_front();
							sent_count++;
							if (!tail_phase && (sent_count / 48) % 3 != 2 &&
									$urandom_range(0, 5) == 0)
								gap_left <= $urandom_range(1, 11);
						end
						ST_LIMIT: begin
							if (quiet_cycles >= SETTLE) begin
								nwe = 1'b1;
								cfg_wdata <= nxt.lim;
								tok_limit <= nxt.lim;
								nxt = pending_steps.pop_front();
							end
						end
						ST_DRAIN: begin
							if (quiet_cycles >= SETTLE)
								nxt = pending_steps.pop_front();
						end
						default: begin
							nhold = 1'b1;
							nxt   = pending_steps.pop_front();
						end
					endcase
				end
			end
			in_valid   <= nv;
			in_data    <= nd;
			cfg_we     <= nwe;
			hold_go    <= nhold;
			tail_phase <= fill_done && pending_steps.size() < TAIL_STEPS;
		end
	end

	// ------------------------------------------------------------------
	// Output back-pressure: random bursts plus one long hold
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : sink_blk
		logic ns;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_left  <= 0;
			stall_left <= 0;
		end else begin
			ns = 1'b0;
			if (hold_go) begin
				hold_left <= LONG_HOLD;
				ns = 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				ns = 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				ns = 1'b1;
			end else if (!tail_phase && (got_count / 40) % 3 != 1 &&
					$urandom_range(0, 6) == 0) begin
				stall_left <= $urandom_range(0, 10);
				ns = 1'b1;
			end
			out_stall <= ns;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
			$time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Monitor: predict on taken requests, check on taken results
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_blk
		out_req_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_tokens(in_data);
			if (out_valid && !out_stall) begin
				got_count++;
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected result", int'(out_data), 0);
				end else begin
					want = expected_tokens.pop_front();
					if (out_data.token_char !== want.token_char)
						report_mismatch("token_char", int'(out_data.token_char),
							int'(want.token_char));
					if (out_data.char_valid !== want.char_valid)
						report_mismatch("char_valid", int'(out_data.char_valid),
							int'(want.char_valid));
					if (out_data.token_end !== want.token_end)
						report_mismatch("token_end", int'(out_data.token_end),
							int'(want.token_end));
					if (out_data.is_operator !== want.is_operator)
						report_mismatch("is_operator", int'(out_data.is_operator),
							int'(want.is_operator));
					if (out_data.command_end !== want.command_end)
						report_mismatch("command_end", int'(out_data.command_end),
							int'(want.command_end));
					if (out_data.overflow_error !== want.overflow_error)
						report_mismatch("overflow_error", int'(out_data.overflow_error),
							int'(want.overflow_error));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Run control
	// ------------------------------------------------------------------
	initial begin
		int phase_start;
		logic [CFG_W-1:0] lim;

		// paired operators, pipe pairing, input redirect at command end
		queue_byte("x", 1'b0);
		queue_byte(CH_AMP, 1'b0);
		queue_byte(CH_AMP, 1'b0);
		queue_byte("y", 1'b0);
		queue_byte(CH_PIPE, 1'b0);
		queue_byte(CH_PIPE, 1'b0);
		queue_byte(CH_LT, 1'b1);
		// append, parens, trailing held operator flushed by command end
		queue_byte(CH_GT, 1'b0);
		queue_byte(CH_GT, 1'b0);
		queue_byte(CH_LPAREN, 1'b0);
		queue_byte(CH_RPAREN, 1'b0);
		queue_byte(CH_GT, 1'b1);
		// subshell keeps space inside the word
		queue_byte(CH_DOLLAR, 1'b0);
		queue_byte(CH_LPAREN, 1'b0);
		queue_byte("a", 1'b0);
		queue_byte(CH_SPACE, 1'b0);
		queue_byte("b", 1'b0);
		queue_byte(CH_RPAREN, 1'b1);
		// empty quotes give no token; lone ampersand at the end
		queue_byte(CH_SQUOTE, 1'b0);
		queue_byte(CH_SQUOTE, 1'b0);
		queue_byte(CH_AMP, 1'b1);
		// trailing backslash alone: bare command end
		queue_byte(CH_BSLASH, 1'b1);
		// extreme bytes, quoted newline
		queue_byte(8'hFF, 1'b0);
		queue_byte(CH_DQUOTE, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_DQUOTE, 1'b0);
		queue_byte(8'h00, 1'b1);
		// overflow with dropped tail, then overflow on the final byte
		queue_mark(ST_LIMIT, 10'd1);
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b0);
		queue_byte("c", 1'b1);
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b1);

		// random phases, one limit setting each
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 10'd0;
				1: lim = 10'd1023;
				2: lim = 10'd2;
				3: lim = CFG_W'($urandom_range(3, 12));
				4: lim = 10'd1022;
				default: lim = 10'd5;
			endcase
			queue_mark(ST_LIMIT, lim);
			if (ph == 1)
				queue_mark(ST_HOLD, '0);
			phase_start = queued_bytes;
			while (queued_bytes - phase_start < 50) begin
				queue_random_command(14);
				if (ph == 3 && queued_bytes - phase_start >= 28 &&
						queued_bytes - phase_start < 42)
					queue_mark(ST_DRAIN, '0);
			end
		end
		fill_done = 1'b1;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		while (pending_steps.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("** shell_command_tokenizer_top: PASSED **");
		else
			$display("** shell_command_tokenizer_top: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("[%0t] timeout with %0d results still expected", $time,
			expected_tokens.size());
		$display("** shell_command_tokenizer_top: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/sct_pkg.sv
rtl/sct_step.sv
rtl/sct_obuf.sv
rtl/shell_command_tokenizer_top.sv
tb/sv/tb_shell_command_tokenizer_top.sv
